// ===== hdl/cgd_pkg.sv =====
// ---------------------------------------------------------------------------
// cgd_pkg: shared types and constants of the greedy CTC decoder
// Field widths, configuration defaults and the payload types of both channels.
// ---------------------------------------------------------------------------
package cgd_pkg;

	localparam int unsigned SCORE_W       = 32;
	localparam int unsigned INDEX_W       = 13;
	localparam int unsigned CFG_W         = 14;
	localparam int unsigned MAX_CLASSES_D = 8192;
	localparam logic [CFG_W-1:0] NUM_CLASSES_RST = CFG_W'(37);

	typedef logic [SCORE_W-1:0] score_t;
	typedef logic [INDEX_W-1:0] index_t;
	typedef logic [CFG_W-1:0]   cfg_t;

	typedef struct packed {
		score_t score;
		logic   first_of_sequence;
	} score_word_t;

	typedef struct packed {
		index_t class_index;
	} index_word_t;

endpackage

// ===== hdl/cgd_if.sv =====
// ---------------------------------------------------------------------------
// cgd_if: valid/ready channels of the greedy CTC decoder
// One channel for score words, one for decoded class index words.
// ---------------------------------------------------------------------------
interface cgd_score_if
	import cgd_pkg::*;
();
	logic        valid;
	logic        ready;
	score_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface cgd_index_if
	import cgd_pkg::*;
();
	logic        valid;
	logic        ready;
	index_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/cgd_flt_lt.sv =====
// ---------------------------------------------------------------------------
// cgd_flt_lt: ordered less-than of two IEEE single values
// False if either side is NaN; -0 and +0 compare equal.
// ---------------------------------------------------------------------------
module cgd_flt_lt
	import cgd_pkg::*;
(
	input  score_t a,
	input  score_t b,
	output logic   lt
);
	logic [SCORE_W-2:0] mag_a, mag_b;
	logic nan_a, nan_b, both_zero;

	assign mag_a     = a[SCORE_W-2:0];
	assign mag_b     = b[SCORE_W-2:0];
	assign nan_a     = (a[30:23] == 8'hFF) && (a[22:0] != '0);
	assign nan_b     = (b[30:23] == 8'hFF) && (b[22:0] != '0);
	assign both_zero = (mag_a == '0) && (mag_b == '0);

	always_comb begin
		if (nan_a || nan_b || both_zero) begin
			lt = 1'b0;
		end else if (a[SCORE_W-1] != b[SCORE_W-1]) begin
			lt = a[SCORE_W-1];
		end else if (a[SCORE_W-1]) begin
			lt = mag_a > mag_b;
		end else begin
			lt = mag_a < mag_b;
		end
	end
endmodule

// ===== hdl/ctc_greedy_decoder_core.sv =====
// ---------------------------------------------------------------------------
// ctc_greedy_decoder_core: streaming greedy CTC decoder
// Running argmax per time step, blank removal and repeat collapse.
// ---------------------------------------------------------------------------
// A step's winner passes the input register stage and then the result register after its last score word.
// Throughput: one score word per cycle while the winners sink does not stall; the single float compare sets it.
// Reset (arst_n low): num_classes back to 37, step counter, best score,
// history and both valid flags cleared.
module ctc_greedy_decoder_core
	import cgd_pkg::*;
#(
	parameter int unsigned MAX_CLASSES = MAX_CLASSES_D
)(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  cfg_t              cfg_data,
	cgd_score_if.sink         scores,
	cgd_index_if.source       winners
);
	localparam int unsigned CW = (MAX_CLASSES > 2) ? $clog2(MAX_CLASSES) : 1;
	localparam int unsigned NW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
	localparam logic [NW-1:0] N_MAX = NW'(MAX_CLASSES);
	localparam logic [NW-1:0] N_MIN = NW'(2);

	// configuration
	cfg_t num_classes_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_classes_q <= NUM_CLASSES_RST;
		end else if (cfg_we) begin
			num_classes_q <= cfg_data;
		end
	end

	// clamp to [2, MAX_CLASSES]
	logic [NW-1:0] n_raw, n_eff;
	assign n_raw = NW'(num_classes_q);
	always_comb begin
		if (n_raw < N_MIN)      n_eff = N_MIN;
		else if (n_raw > N_MAX) n_eff = N_MAX;
		else                    n_eff = n_raw;
	end

	// input register stage
	logic   valid_s1, first_s1, advance;
	score_t score_s1;
	assign advance      = valid_s1 && (!winners.valid || winners.ready);
	assign scores.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scores.ready) begin
			valid_s1 <= scores.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (scores.valid && scores.ready) begin
			score_s1 <= scores.data.score;
			first_s1 <= scores.data.first_of_sequence;
		end
	end

	// step state
	logic [CW-1:0] class_counter_q, best_index_q, prev_winner_q;
	score_t        best_score_q;
	logic          prev_valid_q;

	// a new sequence restarts the step and drops the history
	logic [CW-1:0] cnt;
	logic          pv;
	logic          lt, take;
	logic [CW-1:0] win_idx;
	score_t        win_score;
	logic          step_end, is_blank, repeat_hit, emit;

	assign cnt = first_s1 ? '0 : class_counter_q;
	assign pv  = first_s1 ? 1'b0 : prev_valid_q;

	cgd_flt_lt u_lt (
		.a  (best_score_q),
		.b  (score_s1),
		.lt (lt)
	);

	assign take      = (cnt == '0) || lt;
	assign win_idx   = take ? cnt : best_index_q;
	assign win_score = take ? score_s1 : best_score_q;

	assign step_end   = (NW'(cnt) + NW'(1)) >= n_eff;
	assign is_blank   = NW'(win_idx) == (n_eff - NW'(1));
	assign repeat_hit = pv && (win_idx == prev_winner_q);
	assign emit       = step_end && !is_blank && !repeat_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_counter_q <= '0;
			best_score_q    <= '0;
			best_index_q    <= '0;
			prev_winner_q   <= '0;
			prev_valid_q    <= 1'b0;
		end else if (advance) begin
			best_score_q <= win_score;
			best_index_q <= win_idx;
			if (step_end) begin
				class_counter_q <= '0;
				prev_winner_q   <= win_idx;
				prev_valid_q    <= 1'b1;
			end else begin
				class_counter_q <= cnt + CW'(1);
				prev_winner_q   <= first_s1 ? '0 : prev_winner_q;
				prev_valid_q    <= pv;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			winners.valid <= 1'b0;
		end else if (advance) begin
			winners.valid <= emit;
		end else if (winners.ready) begin
			winners.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			winners.data.class_index <= INDEX_W'(win_idx);
		end
	end
endmodule

// ===== bench/tb_ctc_greedy_decoder_core.sv =====
// ---------------------------------------------------------------------------
// tb_ctc_greedy_decoder_core: self-checking bench of the greedy CTC decoder
// Streams score words with random gaps against a random-stall sink and checks
// every decoded class index against a behavioral argmax/collapse predictor.
// ---------------------------------------------------------------------------
module tb_ctc_greedy_decoder_core;
	import cgd_pkg::*;

	localparam int MAX_CYCLES = 2000000;
	localparam int DRAIN_CYCLES = 8;

	logic clk;
	logic arst_n;
	logic cfg_we;
	cfg_t cfg_data;

	cgd_score_if score_ch ();
	cgd_index_if index_ch ();

	ctc_greedy_decoder_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.scores   (score_ch.sink),
		.winners  (index_ch.source)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// predictor state, mirrors the block's architectural state
	cfg_t   num_classes_q;
	int     step_pos;
	score_t best_bits;
	index_t best_idx;
	index_t prev_winner;
	bit     prev_valid;

	score_word_t pending_words[$];	// words waiting to be sent
	index_t      expected_idx[$];	// decoded indices not yet seen
	int errors;
	int cycle_count;
	int words_sent;
	int indices_seen;
	bit hold_sender;	// sender pause during a class count write

	cfg_t n_list[5] = '{cfg_t'(2), cfg_t'(3), cfg_t'(5), cfg_t'(4), cfg_t'(37)};

	function automatic int phase_goal(input int p);
		return 200 + (p + 1) * 300;
	endfunction

	task automatic report(input string what);
		errors++;
		$display("mismatch @%0d: %s", cycle_count, what);
	endtask

	// strict ordered float compare; NaN on either side gives false, -0 == +0
	function automatic bit float_less(input score_t a, input score_t b);
		bit a_nan;
		bit b_nan;
		logic [30:0] am;
		logic [30:0] bm;
		a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 0);
		b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 0);
		am = a[30:0];
		bm = b[30:0];
		if (a_nan || b_nan)
			return 1'b0;
		if (am == 0 && bm == 0)
			return 1'b0;
		if (a[31] != b[31])
			return a[31];
		if (!a[31])
			return am < bm;
		return am > bm;
	endfunction

	// advance the predictor by one accepted score word
	task automatic predict_step(input score_word_t w);
		int n;
		n = num_classes_q;
		if (n < 2)
			n = 2;
		if (n > MAX_CLASSES_D)
			n = MAX_CLASSES_D;
		if (w.first_of_sequence) begin
			prev_valid = 1'b0;
			prev_winner = '0;
			step_pos = 0;
		end
		if (step_pos == 0) begin
			best_bits = w.score;
			best_idx = '0;
		end else if (float_less(best_bits, w.score)) begin
			best_bits = w.score;
			best_idx = index_t'(step_pos);
		end
		if (step_pos + 1 >= n) begin
			// blank is the last class; repeats collapse unless a blank split them
			if (!(best_idx == index_t'(n - 1)) && !(prev_valid && best_idx == prev_winner))
				expected_idx = {expected_idx, best_idx};
			prev_winner = best_idx;
			prev_valid = 1'b1;
			step_pos = 0;
		end else begin
			step_pos++;
		end
	endtask

	function automatic score_t rand_score();
		case ($urandom_range(0, 9))
			0: return 32'h7FC0_0000 | $urandom_range(0, 32'h3F_FFFF);	// NaN
			1: return {$urandom_range(0, 1) == 1, 31'h0};	// signed zero
			2: return {$urandom_range(0, 1) == 1, 31'h7F80_0000};	// infinity
			3: return 32'h3F80_0000;	// common value, forces ties
			4, 5: return $urandom;
			default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(120, 130)),
				23'($urandom)};
		endcase
	endfunction

	task automatic queue_step(input int n, input bit first_flag, input int win);
		score_word_t w;
		for (int k = 0; k < n; k++) begin
			w.first_of_sequence = first_flag && (k == 0);
			w.score = rand_score();
			if (win >= 0)
				w.score = (k == win) ? 32'h4120_0000 : 32'h3F00_0000;
			pending_words = {pending_words, w};
		end
	endtask

	task automatic wait_drained();
		while (pending_words.size() != 0 || expected_idx.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_classes(input cfg_t v);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		num_classes_q = v;
	endtask

	// driver
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_ch.valid <= 1'b0;
			score_ch.data <= '0;
			gap_left <= 0;
		end else begin
			if (score_ch.valid && score_ch.ready) begin
				predict_step(score_ch.data);
				void'(pending_words.pop_front());
				words_sent++;
			end
			if (score_ch.valid && !score_ch.ready) begin
				// hold the word
			end else if (gap_left > 0) begin
				score_ch.valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (!hold_sender && pending_words.size() != 0) begin
				score_ch.valid <= 1'b1;
				score_ch.data <= pending_words[0];
				gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
			end else begin
				score_ch.valid <= 1'b0;
			end
		end
	end

	// monitor with random stalls
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_ch.ready <= 1'b0;
			stall_left <= 0;
		end else begin
			cycle_count++;
			if (index_ch.valid && index_ch.ready) begin
				indices_seen++;
				if (expected_idx.size() == 0)
					report($sformatf("unexpected index %0d", index_ch.data.class_index));
				else begin
					if (index_ch.data.class_index !== expected_idx[0])
						report($sformatf("class_index %0d, expected %0d",
							index_ch.data.class_index, expected_idx[0]));
					void'(expected_idx.pop_front());
				end
				stall_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
				index_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				index_ch.ready <= 1'b0;
			end else begin
				index_ch.ready <= 1'b1;
			end
			if (cycle_count > MAX_CYCLES) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("** ctc_greedy_decoder_core: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		int n;
		errors = 0;
		cycle_count = 0;
		words_sent = 0;
		indices_seen = 0;
		hold_sender = 1'b0;
		cfg_we = 1'b0;
		cfg_data = NUM_CLASSES_RST;
		num_classes_q = NUM_CLASSES_RST;
		step_pos = 0;
		best_bits = '0;
		best_idx = '0;
		prev_winner = '0;
		prev_valid = 1'b0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset count of 37, blank win, repeats, blank between repeats
		queue_step(37, 1, 5);
		queue_step(37, 0, 5);
		queue_step(37, 0, 36);
		queue_step(37, 0, 5);
		wait_drained();
		write_classes(cfg_t'(3));
		begin
			score_word_t w;
			// ties, signed zeros, NaN first, extremes of the score field
			w = '{score: 32'h8000_0000, first_of_sequence: 1'b1}; pending_words = {pending_words, w};
			w = '{score: 32'h0000_0000, first_of_sequence: 1'b0}; pending_words = {pending_words, w};
			w = '{score: 32'hFFFF_FFFF, first_of_sequence: 1'b0}; pending_words = {pending_words, w};
			w = '{score: 32'h7FC0_0000, first_of_sequence: 1'b0}; pending_words = {pending_words, w};
			w = '{score: 32'h7F80_0000, first_of_sequence: 1'b0}; pending_words = {pending_words, w};
			w = '{score: 32'h0000_0001, first_of_sequence: 1'b0}; pending_words = {pending_words, w};
			w = '{score: 32'hFF80_0000, first_of_sequence: 1'b0}; pending_words = {pending_words, w};
			w = '{score: 32'h7F7F_FFFF, first_of_sequence: 1'b0}; pending_words = {pending_words, w};
			w = '{score: 32'h3F80_0000, first_of_sequence: 1'b1}; pending_words = {pending_words, w};
		end
		// sender pause: wait until every decoded index has arrived, then hold the sender during the class count write
		hold_sender = 1'b0;
		wait_drained();
		hold_sender = 1'b1;
		write_classes(cfg_t'(0));	// acts as 2
		hold_sender = 1'b0;
		queue_step(2, 1, 0);
		queue_step(2, 0, 1);
		queue_step(2, 0, 0);
		wait_drained();

		// random phases over several class counts, most steps small
		foreach (n_list[p]) begin
			write_classes(n_list[p]);
			while (words_sent < phase_goal(p)) begin
				n = (n_list[p] < 2) ? 2 :
					((n_list[p] > MAX_CLASSES_D) ? MAX_CLASSES_D : int'(n_list[p]));
				queue_step(n, $urandom_range(0, 7) == 0,
					($urandom_range(0, 1) == 0) ? $urandom_range(0, n - 1) : -1);
				while (pending_words.size() > 64)
					@(posedge clk);
			end
			wait_drained();
		end
		write_classes(cfg_t'(1));
		queue_step(2, 0, 1);
		wait_drained();

		$display("sent %0d score words over class counts 0..37, checked %0d indices",
			words_sent, indices_seen);
		$display("covered ties, signed zeros, NaN, infinities, blanks, repeat collapse");
		if (errors == 0) begin
			$display("** ctc_greedy_decoder_core: PASSED **");
		end else begin
			$display("** ctc_greedy_decoder_core: FAILED **");
		end
		$finish;
	end

endmodule
